// ===== rtl/tcw_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tcw_pkg - shared definitions of the text console writer
// Screen geometry, cell layout, command codes, controller states and the
// command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package tcw_pkg;

	// Screen geometry
	localparam int COLS   = 80;
	localparam int ROWS   = 25;
	localparam int CELLS  = COLS * ROWS;
	localparam int MOVE   = COLS * (ROWS - 1);
	localparam int ADDR_W = $clog2(CELLS);

	// Field widths
	localparam int CMD_W  = 2;
	localparam int CH_W   = 8;
	localparam int CLR_W  = 4;
	localparam int ROW_W  = 5;
	localparam int COL_W  = 7;
	localparam int CELL_W = 16;

	// Cell layout
	localparam int BG_SHIFT = 12;
	localparam int FG_SHIFT = 8;
	localparam logic [CH_W-1:0] BLANK_CHAR = 8'h20;
	localparam logic [CH_W-1:0] CH_NL      = 8'd10;
	localparam logic [CH_W-1:0] CH_CR      = 8'd13;

	typedef enum logic [CMD_W-1:0] {
		CMD_PUT   = 2'd0,
		CMD_FILL  = 2'd1,
		CMD_CLEAR = 2'd2,
		CMD_READ  = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_EXEC,
		ST_SWEEP,
		ST_RESP
	} state_t;

	// Controller to datapath
	typedef struct packed {
		logic load_item;   // latch the accepted beat
		logic exec;        // update cursor, issue cell write or read
		logic sweep_step;  // advance the whole-screen sweep by one cell
		logic sweep_init;  // sweep writes zero (power-up clear)
		logic load_out;    // load the result register
	} ctl_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic need_sweep;  // item scrolls, fills or clears
		logic sweep_last;  // sweep counter is on the last cell
	} ctl_sts_t;

	// Background-colored blank cell
	function automatic logic [CELL_W-1:0] blank_cell(input logic [CLR_W-1:0] bg);
		blank_cell = (CELL_W'(bg) << BG_SHIFT) | CELL_W'(BLANK_CHAR);
	endfunction

endpackage
`default_nettype wire

// ===== rtl/tcw_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tcw_ram - generic simple dual-port RAM
// One write port, one read port with registered data that holds while idle.
// ----------------------------------------------------------------------------
module tcw_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 2000
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

// ===== rtl/tcw_ctl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tcw_ctl - text console writer controller
// Sequences power-up clear, item execution, screen sweeps and the result
// register handshake.
// ----------------------------------------------------------------------------
module tcw_ctl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             s_tvalid,
	output logic                  s_tready,
	output logic                  m_tvalid,
	input  wire logic             m_tready,
	input  wire tcw_pkg::ctl_sts_t sts,
	output tcw_pkg::ctl_cmd_t     cmd
);

	tcw_pkg::state_t state_q;
	tcw_pkg::state_t state_nxt;
	logic            out_valid_q;

	// Next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			tcw_pkg::ST_INIT: begin
				if (sts.sweep_last) begin
					state_nxt = tcw_pkg::ST_IDLE;
				end
			end
			tcw_pkg::ST_IDLE: begin
				if (s_tvalid) begin
					state_nxt = tcw_pkg::ST_EXEC;
				end
			end
			tcw_pkg::ST_EXEC: begin
				state_nxt = sts.need_sweep ? tcw_pkg::ST_SWEEP : tcw_pkg::ST_RESP;
			end
			tcw_pkg::ST_SWEEP: begin
				if (sts.sweep_last) begin
					state_nxt = tcw_pkg::ST_RESP;
				end
			end
			tcw_pkg::ST_RESP: begin
				if (!out_valid_q || m_tready) begin
					state_nxt = tcw_pkg::ST_IDLE;
				end
			end
			default: state_nxt = tcw_pkg::ST_IDLE;
		endcase
	end

	// Outputs per state
	always_comb begin
		cmd      = '0;
		s_tready = 1'b0;
		case (state_q)
			tcw_pkg::ST_INIT: begin
				cmd.sweep_step = 1'b1;
				cmd.sweep_init = 1'b1;
			end
			tcw_pkg::ST_IDLE: begin
				s_tready      = 1'b1;
				cmd.load_item = s_tvalid;
			end
			tcw_pkg::ST_EXEC: begin
				cmd.exec = 1'b1;
			end
			tcw_pkg::ST_SWEEP: begin
				cmd.sweep_step = 1'b1;
			end
			tcw_pkg::ST_RESP: begin
				cmd.load_out = !out_valid_q || m_tready;
			end
			default: ;
		endcase
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tcw_pkg::ST_INIT;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Result valid: set on load, drop when the beat is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign m_tvalid = out_valid_q;

`ifndef SYNTHESIS
	// Never overwrite a result beat that is still waiting
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> (!out_valid_q || m_tready))
		else $error("result register overwritten while stalled");

	// Power-up clear ends in idle after the last cell
	a_init_exit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == tcw_pkg::ST_INIT && sts.sweep_last) |=> state_q == tcw_pkg::ST_IDLE)
		else $error("clear pass did not end in idle");

	// Every accepted beat moves the controller into the execute state
	a_accept_to_exec: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> state_q == tcw_pkg::ST_EXEC)
		else $error("accepted beat not executed");
`endif

endmodule
`default_nettype wire

// ===== rtl/tcw_dp.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tcw_dp - text console writer datapath
// Holds the item, the cursor, the screen store and the result register;
// runs the one-cell-per-cycle sweep for clear, fill and scroll.
// ----------------------------------------------------------------------------
module tcw_dp (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire tcw_pkg::cmd_t               in_cmd,
	input  wire logic [tcw_pkg::CH_W-1:0]    in_ch,
	input  wire logic [tcw_pkg::CLR_W-1:0]   in_fg,
	input  wire logic [tcw_pkg::CLR_W-1:0]   in_bg,
	input  wire logic [tcw_pkg::ROW_W-1:0]   in_row,
	input  wire logic [tcw_pkg::COL_W-1:0]   in_col,
	input  wire tcw_pkg::ctl_cmd_t           cmd,
	output tcw_pkg::ctl_sts_t                sts,
	output logic      [tcw_pkg::CELL_W-1:0]  cell_word,
	output logic      [tcw_pkg::ROW_W-1:0]   cur_row,
	output logic      [tcw_pkg::COL_W-1:0]   cur_col,
	output logic                             scrolled
);

	localparam int AW = tcw_pkg::ADDR_W;
	localparam int RW = tcw_pkg::ROW_W;
	localparam int CW = tcw_pkg::COL_W;
	localparam logic [AW-1:0] COLS_A = AW'(tcw_pkg::COLS);
	localparam logic [AW-1:0] MOVE_A = AW'(tcw_pkg::MOVE);
	localparam logic [AW-1:0] LAST_A = AW'(tcw_pkg::CELLS - 1);
	localparam logic [RW-1:0] ROW_LAST = RW'(tcw_pkg::ROWS - 1);
	localparam logic [CW-1:0] COL_LAST = CW'(tcw_pkg::COLS - 1);

	// Latched item
	tcw_pkg::cmd_t              cmd_q;
	logic [tcw_pkg::CH_W-1:0]   ch_q;
	logic [tcw_pkg::CLR_W-1:0]  fg_q;
	logic [tcw_pkg::CLR_W-1:0]  bg_q;
	logic [RW-1:0]              rrow_q;
	logic [CW-1:0]              rcol_q;

	// Cursor and per-item state
	logic [RW-1:0] cur_row_q;
	logic [CW-1:0] cur_col_q;
	logic          scroll_q;
	logic          rd_ok_q;
	logic [AW-1:0] cnt_q;

	// Write stage
	logic                       we_s1;
	logic [AW-1:0]              wa_s1;
	logic [tcw_pkg::CELL_W-1:0] wd_s1;
	logic                       from_ram_s1;

	// Result register
	logic [tcw_pkg::CELL_W-1:0] cell_q;
	logic [RW-1:0]              out_row_q;
	logic [CW-1:0]              out_col_q;
	logic                       out_scr_q;

	// Combinational helpers
	logic [RW-1:0]              nxt_row;
	logic [CW-1:0]              nxt_col;
	logic                       do_scroll;
	logic                       put_wr;
	logic                       rd_ok;
	logic                       in_move;
	logic [AW-1:0]              cur_addr;
	logic [AW-1:0]              rd_addr_item;
	logic [tcw_pkg::CELL_W-1:0] sweep_word;
	logic [tcw_pkg::CELL_W-1:0] char_word;
	logic                       ram_re;
	logic [AW-1:0]              ram_raddr;
	logic [tcw_pkg::CELL_W-1:0] ram_wdata;
	logic [tcw_pkg::CELL_W-1:0] ram_rdata;

	// Latch the accepted beat
	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			cmd_q  <= in_cmd;
			ch_q   <= in_ch;
			fg_q   <= in_fg;
			bg_q   <= in_bg;
			rrow_q <= in_row;
			rcol_q <= in_col;
		end
	end

	// Cursor movement for the latched item
	always_comb begin
		nxt_row   = cur_row_q;
		nxt_col   = cur_col_q;
		do_scroll = 1'b0;
		put_wr    = 1'b0;
		case (cmd_q)
			tcw_pkg::CMD_PUT: begin
				if (ch_q == tcw_pkg::CH_NL) begin
					if (cur_row_q == ROW_LAST) begin
						do_scroll = 1'b1;
					end else begin
						nxt_row = cur_row_q + RW'(1);
					end
				end else if (ch_q == tcw_pkg::CH_CR) begin
					nxt_col = '0;
				end else begin
					put_wr = 1'b1;
					if (cur_col_q == COL_LAST) begin
						nxt_col = '0;
						if (cur_row_q == ROW_LAST) begin
							do_scroll = 1'b1;
						end else begin
							nxt_row = cur_row_q + RW'(1);
						end
					end else begin
						nxt_col = cur_col_q + CW'(1);
					end
				end
			end
			tcw_pkg::CMD_CLEAR: begin
				nxt_row = '0;
				nxt_col = '0;
			end
			default: ;
		endcase
	end

	assign rd_ok = (cmd_q == tcw_pkg::CMD_READ)
		&& (rrow_q < RW'(tcw_pkg::ROWS)) && (rcol_q < CW'(tcw_pkg::COLS));

	assign sts.need_sweep = do_scroll || (cmd_q == tcw_pkg::CMD_FILL)
		|| (cmd_q == tcw_pkg::CMD_CLEAR);
	assign sts.sweep_last = (cnt_q == LAST_A);

	// Cell addresses and words
	assign cur_addr     = AW'(cur_row_q) * COLS_A + AW'(cur_col_q);
	assign rd_addr_item = AW'(rrow_q) * COLS_A + AW'(rcol_q);
	assign char_word    = {bg_q, fg_q, ch_q};
	assign in_move      = (cnt_q < MOVE_A);

	// Sweep word: zero at power-up, blank on bg for fill and scroll, plain blank for clear
	always_comb begin
		if (cmd.sweep_init) begin
			sweep_word = '0;
		end else if (!scroll_q && cmd_q == tcw_pkg::CMD_CLEAR) begin
			sweep_word = tcw_pkg::blank_cell('0);
		end else begin
			sweep_word = tcw_pkg::blank_cell(bg_q);
		end
	end

	// Read port: item read, or the row below during a scroll sweep
	always_comb begin
		ram_re    = 1'b0;
		ram_raddr = rd_addr_item;
		if (cmd.exec) begin
			ram_re = rd_ok;
		end else if (cmd.sweep_step && !cmd.sweep_init && scroll_q && in_move) begin
			ram_re    = 1'b1;
			ram_raddr = cnt_q + COLS_A;
		end
	end

	// Cursor, scroll flag and read-valid update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_row_q <= '0;
			cur_col_q <= '0;
			scroll_q  <= 1'b0;
			rd_ok_q   <= 1'b0;
		end else if (cmd.exec) begin
			cur_row_q <= nxt_row;
			cur_col_q <= nxt_col;
			scroll_q  <= do_scroll;
			rd_ok_q   <= rd_ok;
		end
	end

	// Sweep counter: restart on exec, advance one cell per step
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.exec) begin
			cnt_q <= '0;
		end else if (cmd.sweep_step) begin
			cnt_q <= cnt_q + AW'(1);
		end
	end

	// Write stage: lags the read by a register so moved cells come from the RAM
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			we_s1 <= 1'b0;
		end else begin
			we_s1 <= (cmd.exec && put_wr) || cmd.sweep_step;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			wa_s1       <= cur_addr;
			wd_s1       <= char_word;
			from_ram_s1 <= 1'b0;
		end else begin
			wa_s1       <= cnt_q;
			wd_s1       <= sweep_word;
			from_ram_s1 <= !cmd.sweep_init && scroll_q && in_move;
		end
	end

	assign ram_wdata = from_ram_s1 ? ram_rdata : wd_s1;

	tcw_ram #(
		.WIDTH (tcw_pkg::CELL_W),
		.DEPTH (tcw_pkg::CELLS)
	) u_screen (
		.clk   (clk),
		.we    (we_s1),
		.waddr (wa_s1),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Result register
	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			cell_q    <= rd_ok_q ? ram_rdata : '0;
			out_row_q <= cur_row_q;
			out_col_q <= cur_col_q;
			out_scr_q <= scroll_q;
		end
	end

	assign cell_word = cell_q;
	assign cur_row   = out_row_q;
	assign cur_col   = out_col_q;
	assign scrolled  = out_scr_q;

`ifndef SYNTHESIS
	// Cursor stays on the screen
	a_cursor_range: assert property (@(posedge clk) disable iff (!arst_n)
		(cur_row_q <= ROW_LAST) && (cur_col_q <= COL_LAST))
		else $error("cursor left the screen");

	// Writes stay inside the store
	a_write_range: assert property (@(posedge clk) disable iff (!arst_n)
		we_s1 |-> (wa_s1 <= LAST_A))
		else $error("cell write beyond the store");
`endif

endmodule
`default_nettype wire

// ===== rtl/text_console_writer_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// text_console_writer_unit - 80x25 text console writer
// Puts characters at a cursor with newline, carriage return, wrap and
// scroll; fills, clears and reads back the 16-bit cell store.
//
// Channel  Dir  Signals                      Meaning
// s_*      in   tvalid tready tdata tuser    one command beat
// m_*      out  tvalid tready tdata          one result beat per command
//
// Put character, newline, carriage return and read pass through latch,
// execute and result. Fill, clear and any scroll add a sweep over every
// screen cell (2000) to walk the single-write-port screen RAM.
// After reset a clearing pass over every cell zeroes the RAM; s_tready stays
// low meanwhile. One command is in work at a time; a stalled result beat
// holds in the output register while the next command is taken.
// ----------------------------------------------------------------------------
module text_console_writer_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [31:0] s_tdata,  // ch[7:0] fg[11:8] bg[15:12] row[20:16] col[27:21]
	input  wire logic [1:0]  s_tuser,  // cmd[1:0]
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic      [31:0] m_tdata   // cell_word[15:0] cur_row[20:16] cur_col[27:21]
	                                   // scrolled[28]
);

	tcw_pkg::ctl_cmd_t                ctl_cmd;
	tcw_pkg::ctl_sts_t                ctl_sts;
	logic [tcw_pkg::CELL_W-1:0]       cell_word;
	logic [tcw_pkg::ROW_W-1:0]        cur_row;
	logic [tcw_pkg::COL_W-1:0]        cur_col;
	logic                             scrolled;

	tcw_ctl u_ctl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.sts      (ctl_sts),
		.cmd      (ctl_cmd)
	);

	tcw_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_cmd    (tcw_pkg::cmd_t'(s_tuser)),
		.in_ch     (s_tdata[7:0]),
		.in_fg     (s_tdata[11:8]),
		.in_bg     (s_tdata[15:12]),
		.in_row    (s_tdata[20:16]),
		.in_col    (s_tdata[27:21]),
		.cmd       (ctl_cmd),
		.sts       (ctl_sts),
		.cell_word (cell_word),
		.cur_row   (cur_row),
		.cur_col   (cur_col),
		.scrolled  (scrolled)
	);

	// Pack the result beat
	assign m_tdata = {3'b000, scrolled, cur_col, cur_row, cell_word};

endmodule
`default_nettype wire
